[rtl/jbe_pkg.sv]
package jbe_pkg;

   // Channel payload widths
   localparam int COEFF_W     = 11;
   localparam int COMP_W      = 2;
   localparam int CODE_BITS_W = 27;
   localparam int CODE_LEN_W  = 5;

   // Block geometry
   localparam int BLOCK_COEFFS = 64;
   localparam int POS_W        = $clog2(BLOCK_COEFFS);

   // DC difference / AC value carried with one extra bit over the coefficient
   localparam int DIFF_W = COEFF_W + 1;
   localparam int MAG_W  = COEFF_W;
   localparam int SIZE_W = 4;

   // Huffman code and length widths
   localparam int HUFF_W     = 16;
   localparam int HUFF_LEN_W = 5;

   // Component codes
   localparam logic [COMP_W-1:0] COMP_Y    = 2'd0;
   localparam logic [COMP_W-1:0] COMP_CB   = 2'd1;
   localparam logic [COMP_W-1:0] COMP_CR   = 2'd2;
   localparam logic [COMP_W-1:0] COMP_RSVD = 2'd3;

   // Special AC symbols
   localparam logic [7:0] ZRL_SYM = 8'hF0;
   localparam logic [7:0] EOB_SYM = 8'h00;
   localparam int         ZRL_RUN = 16;

   typedef logic [7:0]            count_list_type [16];
   typedef logic [7:0]            sym_list_type   [162];
   typedef logic [HUFF_W-1:0]     code_rom_type   [256];
   typedef logic [HUFF_LEN_W-1:0] len_rom_type    [256];

   // Canonical code assignment from the standard count / symbol lists
   function automatic code_rom_type build_code_rom(input count_list_type counts,
                                                  input sym_list_type syms);
      code_rom_type      rom;
      logic [HUFF_W-1:0] code;
      int                k;
      rom  = '{default: '0};
      code = '0;
      k    = 0;
      for (int l = 0; l < 16; l++) begin
         for (int j = 0; j < 256; j++) begin
            if (j < int'(counts[l])) begin
               rom[syms[k]] = code;
               code         = code + HUFF_W'(1);
               k            = k + 1;
            end
         end
         code = {code[HUFF_W-2:0], 1'b0};
      end
      return rom;
   endfunction

   function automatic len_rom_type build_len_rom(input count_list_type counts,
                                                input sym_list_type syms);
      len_rom_type rom;
      int          k;
      rom = '{default: '0};
      k   = 0;
      for (int l = 0; l < 16; l++) begin
         for (int j = 0; j < 256; j++) begin
            if (j < int'(counts[l])) begin
               rom[syms[k]] = HUFF_LEN_W'(l + 1);
               k            = k + 1;
            end
         end
      end
      return rom;
   endfunction

   localparam count_list_type DCL_COUNTS = '{
      8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
   localparam count_list_type DCC_COUNTS = '{
      8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
   localparam count_list_type ACL_COUNTS = '{
      8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
      8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d};
   localparam count_list_type ACC_COUNTS = '{
      8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
      8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77};

   localparam sym_list_type DC_SYMS = '{
      0: 8'd0, 1: 8'd1, 2: 8'd2, 3: 8'd3, 4: 8'd4, 5: 8'd5,
      6: 8'd6, 7: 8'd7, 8: 8'd8, 9: 8'd9, 10: 8'd10, 11: 8'd11,
      default: 8'd0};

   localparam sym_list_type ACL_SYMS = '{
      8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
      8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
      8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
      8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
      8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
      8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
      8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
      8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
      8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
      8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
      8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
      8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

   localparam sym_list_type ACC_SYMS = '{
      8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
      8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
      8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
      8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
      8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
      8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
      8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
      8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
      8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
      8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
      8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
      8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

   // Fixed Huffman ROMs, indexed by symbol
   localparam code_rom_type DCL_CODE = build_code_rom(DCL_COUNTS, DC_SYMS);
   localparam len_rom_type  DCL_LEN  = build_len_rom(DCL_COUNTS, DC_SYMS);
   localparam code_rom_type DCC_CODE = build_code_rom(DCC_COUNTS, DC_SYMS);
   localparam len_rom_type  DCC_LEN  = build_len_rom(DCC_COUNTS, DC_SYMS);
   localparam code_rom_type ACL_CODE = build_code_rom(ACL_COUNTS, ACL_SYMS);
   localparam len_rom_type  ACL_LEN  = build_len_rom(ACL_COUNTS, ACL_SYMS);
   localparam code_rom_type ACC_CODE = build_code_rom(ACC_COUNTS, ACC_SYMS);
   localparam len_rom_type  ACC_LEN  = build_len_rom(ACC_COUNTS, ACC_SYMS);

   localparam logic [HUFF_W-1:0]     ZRL_LUMA_CODE   = ACL_CODE[ZRL_SYM];
   localparam logic [HUFF_LEN_W-1:0] ZRL_LUMA_LEN    = ACL_LEN[ZRL_SYM];
   localparam logic [HUFF_W-1:0]     ZRL_CHROMA_CODE = ACC_CODE[ZRL_SYM];
   localparam logic [HUFF_LEN_W-1:0] ZRL_CHROMA_LEN  = ACC_LEN[ZRL_SYM];

endpackage

[rtl/jbe_req_if.sv]
interface jbe_req_if;
   import jbe_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COEFF_W-1:0] coefficient;
   logic [COMP_W-1:0]         component;

   modport source (output valid, output coefficient, output component, input ready);
   modport sink   (input valid, input coefficient, input component, output ready);
endinterface

[rtl/jbe_rsp_if.sv]
interface jbe_rsp_if;
   import jbe_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CODE_BITS_W-1:0] code_bits;
   logic [CODE_LEN_W-1:0]  code_length;
   logic                   block_end;
   logic                   last_of_run;

   modport source (output valid, output code_bits, output code_length, output block_end,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_bits, input code_length, input block_end,
                   input last_of_run, output ready);
endinterface

[rtl/jpeg_block_entropy_encoder.sv]
// A coding request enters the stage buffer, then the output register once that frees.
// Throughput: one request per cycle while each request makes at most one code word and
//   the response side is ready; a request making k code words (ZRLs plus its code) holds
//   the output until all k leave, the one-entry stage buffer takes the next, later ones wait.
// Reset (synchronous, active high): clears block position, zero run, the three DC
//   predictors and both stage valids; no clearing pass, ready again the next cycle.
module jpeg_block_entropy_encoder (
   input logic        clock,
   input logic        reset,
   jbe_req_if.sink    req_ch,
   jbe_rsp_if.source  rsp_ch
);
   import jbe_pkg::*;

   // Work left for the code stage after the block state has been applied
   typedef struct packed {
      logic                     dc;        // DC difference code
      logic                     eob;       // end of block, no magnitude
      logic                     chroma;    // chroma tables
      logic signed [DIFF_W-1:0] value;     // DC difference or saturated AC value
      logic [1:0]               zrl;       // ZRL words to send first
      logic [3:0]               run;       // run part of the AC symbol
      logic                     block_end;
   } stage_type;

   // ---------------------------------------------------------------------------
   // Block state: position, pending zero run, DC predictor per component
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [POS_W-1:0]          run_ff, run_in;
   logic signed [COEFF_W-1:0] pred_ff [3];
   logic signed [COEFF_W-1:0] pred_in [3];

   // Stage buffer between request side and code stage
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;

   // Output register
   logic                   o_valid_ff, o_valid_in;
   logic [1:0]             o_zrl_ff, o_zrl_in;
   logic                   o_chroma_ff, o_chroma_in;
   logic [CODE_BITS_W-1:0] o_bits_ff, o_bits_in;
   logic [CODE_LEN_W-1:0]  o_len_ff, o_len_in;
   logic                   o_end_ff, o_end_in;

   // Handshake
   logic req_fire, rsp_fire;
   logic o_free, s1_move;
   logic zrl_pending;

   // Request-side decode
   logic [COMP_W-1:0]         comp_idx;
   logic                      is_dc, is_last, coef_zero, makes_code;
   logic signed [COEFF_W-1:0] coef, ac_val, pred_sel;
   logic signed [DIFF_W-1:0]  dc_diff;
   stage_type                 item;

   // Code stage
   logic [DIFF_W-1:0]     abs_val;
   logic [MAG_W-1:0]      mag;
   logic [SIZE_W-1:0]     size;
   logic [DIFF_W-1:0]     ones_comp;
   logic [DIFF_W-1:0]     size_mask;
   logic [MAG_W-1:0]      extra_bits;
   logic [7:0]            sym;
   logic [HUFF_W-1:0]     huff_code;
   logic [HUFF_LEN_W-1:0] huff_len;

   // ---------------------------------------------------------------------------
   // Flow control. The output register frees up when it is empty or its last
   // word leaves; the stage buffer then moves down and a new request can enter.
   // ---------------------------------------------------------------------------
   assign zrl_pending  = (o_zrl_ff != 2'd0);
   assign o_free       = !o_valid_ff || (rsp_ch.ready && !zrl_pending);
   assign s1_move      = s1_valid_ff && o_free;
   assign req_ch.ready = !s1_valid_ff || o_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = o_valid_ff && rsp_ch.ready;

   // ---------------------------------------------------------------------------
   // Request decode against block state
   // ---------------------------------------------------------------------------
   assign coef      = req_ch.coefficient;
   // reserved component code uses the Cr tables and predictor
   assign comp_idx  = (req_ch.component == COMP_RSVD) ? COMP_CR : req_ch.component;
   assign pred_sel  = pred_ff[comp_idx];
   assign is_dc     = (pos_ff == '0);
   assign is_last   = (pos_ff == POS_W'(BLOCK_COEFFS - 1));
   assign coef_zero = (coef == '0);
   // zero AC coefficients only grow the run, except at the last position (EOB)
   assign makes_code = is_dc || !coef_zero || is_last;

   // Both operands stay within 11 bits, so the 12-bit difference never needs
   // the +/-2047 clamp.
   assign dc_diff = {coef[COEFF_W-1], coef} - {pred_sel[COEFF_W-1], pred_sel};

   // most negative AC value saturates so the size stays at 10
   assign ac_val = (coef == {1'b1, {(COEFF_W-1){1'b0}}}) ?
                   {1'b1, {(COEFF_W-2){1'b0}}, 1'b1} : coef;

   always_comb begin
      item           = '0;
      item.chroma    = (comp_idx != COMP_Y);
      if (is_dc) begin
         item.dc        = 1'b1;
         item.value     = dc_diff;
      end else if (coef_zero) begin
         item.eob       = 1'b1;
         item.block_end = 1'b1;
      end else begin
         item.value     = {ac_val[COEFF_W-1], ac_val};
         item.zrl       = run_ff[POS_W-1:4];
         item.run       = run_ff[3:0];
         item.block_end = is_last;
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      run_in  = run_ff;
      pred_in = pred_ff;
      if (req_fire) begin
         pos_in = is_last ? '0 : pos_ff + POS_W'(1);
         if (is_dc) begin
            run_in            = '0;
            pred_in[comp_idx] = coef;
         end else if (coef_zero) begin
            run_in = run_ff + POS_W'(1);
         end else begin
            run_in = '0;
         end
      end
   end

   assign s1_valid_in = (req_fire && makes_code) || (s1_valid_ff && !o_free);
   assign s1_in       = (req_fire && makes_code) ? item : s1_ff;

   // ---------------------------------------------------------------------------
   // Code stage: size category, magnitude bits, Huffman lookup, packing
   // ---------------------------------------------------------------------------
   assign abs_val = s1_ff.value[DIFF_W-1] ? -s1_ff.value : s1_ff.value;
   assign mag     = abs_val[MAG_W-1:0];

   always_comb begin
      size = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (mag[i]) begin
            size = SIZE_W'(i + 1);
         end
      end
   end

   // negative values send the one's complement of the magnitude
   assign ones_comp  = s1_ff.value[DIFF_W-1] ? s1_ff.value - DIFF_W'(1) : s1_ff.value;
   assign size_mask  = (DIFF_W'(1) << size) - DIFF_W'(1);
   assign extra_bits = MAG_W'(ones_comp & size_mask);

   always_comb begin
      if (s1_ff.eob) begin
         sym = EOB_SYM;
      end else if (s1_ff.dc) begin
         sym = {4'd0, size};
      end else begin
         sym = {s1_ff.run, size};
      end
   end

   always_comb begin
      case ({s1_ff.dc, s1_ff.chroma})
         2'b10: begin
            huff_code = DCL_CODE[sym];
            huff_len  = DCL_LEN[sym];
         end
         2'b11: begin
            huff_code = DCC_CODE[sym];
            huff_len  = DCC_LEN[sym];
         end
         2'b01: begin
            huff_code = ACC_CODE[sym];
            huff_len  = ACC_LEN[sym];
         end
         default: begin
            huff_code = ACL_CODE[sym];
            huff_len  = ACL_LEN[sym];
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Output register: ZRL words first (count down), then the item's own code
   // ---------------------------------------------------------------------------
   always_comb begin
      o_valid_in  = o_valid_ff;
      o_zrl_in    = o_zrl_ff;
      o_chroma_in = o_chroma_ff;
      o_bits_in   = o_bits_ff;
      o_len_in    = o_len_ff;
      o_end_in    = o_end_ff;
      if (s1_move) begin
         o_valid_in  = 1'b1;
         o_zrl_in    = s1_ff.zrl;
         o_chroma_in = s1_ff.chroma;
         o_bits_in   = (CODE_BITS_W'(huff_code) << size) | CODE_BITS_W'(extra_bits);
         o_len_in    = CODE_LEN_W'(huff_len) + CODE_LEN_W'(size);
         o_end_in    = s1_ff.block_end;
      end else if (rsp_fire) begin
         if (zrl_pending) begin
            o_zrl_in = o_zrl_ff - 2'd1;
         end else begin
            o_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_ch.valid = o_valid_ff;
      if (zrl_pending) begin
         rsp_ch.code_bits   = o_chroma_ff ? CODE_BITS_W'(ZRL_CHROMA_CODE)
                                          : CODE_BITS_W'(ZRL_LUMA_CODE);
         rsp_ch.code_length = o_chroma_ff ? CODE_LEN_W'(ZRL_CHROMA_LEN)
                                          : CODE_LEN_W'(ZRL_LUMA_LEN);
         rsp_ch.block_end   = 1'b0;
         rsp_ch.last_of_run = 1'b0;
      end else begin
         rsp_ch.code_bits   = o_bits_ff;
         rsp_ch.code_length = o_len_ff;
         rsp_ch.block_end   = o_end_ff;
         rsp_ch.last_of_run = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         run_ff      <= '0;
         pred_ff     <= '{default: '0};
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
         o_zrl_ff    <= '0;
      end else begin
         pos_ff      <= pos_in;
         run_ff      <= run_in;
         pred_ff     <= pred_in;
         s1_valid_ff <= s1_valid_in;
         o_valid_ff  <= o_valid_in;
         o_zrl_ff    <= o_zrl_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      o_chroma_ff <= o_chroma_in;
      o_bits_ff   <= o_bits_in;
      o_len_ff    <= o_len_in;
      o_end_ff    <= o_end_in;
   end

endmodule

[rtl/jbe_checker.sv]
module jbe_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [jbe_pkg::CODE_BITS_W-1:0] rsp_code_bits,
   input logic [jbe_pkg::CODE_LEN_W-1:0]  rsp_code_length,
   input logic                            rsp_block_end,
   input logic                            rsp_last_of_run
);
   import jbe_pkg::*;

   logic             req_fire, rsp_fire;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       open_ff, open_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // blocks started (DC request taken) but not yet closed by a block_end word
   always_comb begin
      pos_in  = pos_ff;
      open_in = open_ff;
      if (req_fire) begin
         pos_in = (pos_ff == POS_W'(BLOCK_COEFFS - 1)) ? '0 : pos_ff + POS_W'(1);
      end
      if (req_fire && (pos_ff == '0) && !(rsp_fire && rsp_block_end)) begin
         open_in = open_ff + 3'd1;
      end else if (!(req_fire && (pos_ff == '0)) && rsp_fire && rsp_block_end) begin
         open_in = open_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         open_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_bits) &&
      $stable(rsp_code_length) && $stable(rsp_block_end) && $stable(rsp_last_of_run))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_end_has_block: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_block_end |-> open_ff != 3'd0)
      else $error("block_end without an open block");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside the words of one request");

endmodule

bind jpeg_block_entropy_encoder jbe_checker u_jbe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_code_bits   (rsp_ch.code_bits),
   .rsp_code_length (rsp_ch.code_length),
   .rsp_block_end   (rsp_ch.block_end),
   .rsp_last_of_run (rsp_ch.last_of_run)
);

[tb/jbe_huffman_checker.sv]
`timescale 1ns / 100ps

module jbe_huffman_checker (
   input  logic clock,
   input  logic reset,
   jbe_req_if   req_mon,
   jbe_rsp_if   rsp_mon,
   output int   mismatches,
   output int   words_pending,
   output int   words_checked,
   output int   zrl_words,
   output int   eob_words
);
   import jbe_pkg::*;

   typedef enum int {DC_LUMA, AC_LUMA, DC_CHR, AC_CHR} huff_table_type;

   typedef struct packed {
      logic [CODE_BITS_W-1:0] bits;
      logic [CODE_LEN_W-1:0]  length;
      logic                   block_end;
      logic                   last_of_run;
   } code_word_type;

   // Standard code-length counts and symbol orders
   localparam count_list_type LUMA_DC_COUNTS   = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
   localparam count_list_type CHROMA_DC_COUNTS = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
   localparam count_list_type LUMA_AC_COUNTS   = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,'h7d};
   localparam count_list_type CHROMA_AC_COUNTS = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,'h77};

   localparam sym_list_type LUMA_AC_SYMS = '{
      'h01,'h02,'h03,'h00,'h04,'h11,'h05,'h12,'h21,'h31,'h41,'h06,'h13,'h51,'h61,'h07,
      'h22,'h71,'h14,'h32,'h81,'h91,'ha1,'h08,'h23,'h42,'hb1,'hc1,'h15,'h52,'hd1,'hf0,
      'h24,'h33,'h62,'h72,'h82,'h09,'h0a,'h16,'h17,'h18,'h19,'h1a,'h25,'h26,'h27,'h28,
      'h29,'h2a,'h34,'h35,'h36,'h37,'h38,'h39,'h3a,'h43,'h44,'h45,'h46,'h47,'h48,'h49,
      'h4a,'h53,'h54,'h55,'h56,'h57,'h58,'h59,'h5a,'h63,'h64,'h65,'h66,'h67,'h68,'h69,
      'h6a,'h73,'h74,'h75,'h76,'h77,'h78,'h79,'h7a,'h83,'h84,'h85,'h86,'h87,'h88,'h89,
      'h8a,'h92,'h93,'h94,'h95,'h96,'h97,'h98,'h99,'h9a,'ha2,'ha3,'ha4,'ha5,'ha6,'ha7,
      'ha8,'ha9,'haa,'hb2,'hb3,'hb4,'hb5,'hb6,'hb7,'hb8,'hb9,'hba,'hc2,'hc3,'hc4,'hc5,
      'hc6,'hc7,'hc8,'hc9,'hca,'hd2,'hd3,'hd4,'hd5,'hd6,'hd7,'hd8,'hd9,'hda,'he1,'he2,
      'he3,'he4,'he5,'he6,'he7,'he8,'he9,'hea,'hf1,'hf2,'hf3,'hf4,'hf5,'hf6,'hf7,'hf8,
      'hf9,'hfa};

   localparam sym_list_type CHROMA_AC_SYMS = '{
      'h00,'h01,'h02,'h03,'h11,'h04,'h05,'h21,'h31,'h06,'h12,'h41,'h51,'h07,'h61,'h71,
      'h13,'h22,'h32,'h81,'h08,'h14,'h42,'h91,'ha1,'hb1,'hc1,'h09,'h23,'h33,'h52,'hf0,
      'h15,'h62,'h72,'hd1,'h0a,'h16,'h24,'h34,'he1,'h25,'hf1,'h17,'h18,'h19,'h1a,'h26,
      'h27,'h28,'h29,'h2a,'h35,'h36,'h37,'h38,'h39,'h3a,'h43,'h44,'h45,'h46,'h47,'h48,
      'h49,'h4a,'h53,'h54,'h55,'h56,'h57,'h58,'h59,'h5a,'h63,'h64,'h65,'h66,'h67,'h68,
      'h69,'h6a,'h73,'h74,'h75,'h76,'h77,'h78,'h79,'h7a,'h82,'h83,'h84,'h85,'h86,'h87,
      'h88,'h89,'h8a,'h92,'h93,'h94,'h95,'h96,'h97,'h98,'h99,'h9a,'ha2,'ha3,'ha4,'ha5,
      'ha6,'ha7,'ha8,'ha9,'haa,'hb2,'hb3,'hb4,'hb5,'hb6,'hb7,'hb8,'hb9,'hba,'hc2,'hc3,
      'hc4,'hc5,'hc6,'hc7,'hc8,'hc9,'hca,'hd2,'hd3,'hd4,'hd5,'hd6,'hd7,'hd8,'hd9,'hda,
      'he2,'he3,'he4,'he5,'he6,'he7,'he8,'he9,'hea,'hf2,'hf3,'hf4,'hf5,'hf6,'hf7,'hf8,
      'hf9,'hfa};

   logic [15:0]             huff_code [4][256];
   logic [4:0]              huff_len  [4][256];
   sym_list_type            dc_syms;

   logic signed [11:0]      dc_prev [3];
   logic [5:0]              zero_run;
   logic [5:0]              coeff_pos;
   code_word_type           pending_codes [$];
   code_word_type           want;

   task automatic fill_table(input huff_table_type t, input count_list_type counts,
                             input sym_list_type syms);
      logic [15:0] code;
      int          k;
      code = '0;
      k    = 0;
      for (int l = 0; l < 16; l++) begin
         for (int j = 0; j < int'(counts[l]); j++) begin
            huff_code[t][syms[k]] = code;
            huff_len[t][syms[k]]  = 5'(l + 1);
            code++;
            k++;
         end
         code = code << 1;
      end
   endtask

   initial begin
      for (int t = 0; t < 4; t++) begin
         for (int s = 0; s < 256; s++) begin
            huff_code[t][s] = '0;
            huff_len[t][s]  = '0;
         end
      end
      for (int i = 0; i < 162; i++) begin
         dc_syms[i] = (i < 12) ? 8'(i) : 8'd0;
      end
      fill_table(DC_LUMA, LUMA_DC_COUNTS, dc_syms);
      fill_table(AC_LUMA, LUMA_AC_COUNTS, LUMA_AC_SYMS);
      fill_table(DC_CHR, CHROMA_DC_COUNTS, dc_syms);
      fill_table(AC_CHR, CHROMA_AC_COUNTS, CHROMA_AC_SYMS);
   end

   function automatic int magnitude_size(input int v);
      int m;
      int n;
      m = (v < 0) ? -v : v;
      n = 0;
      while (m != 0) begin
         m = m >> 1;
         n++;
      end
      return n;
   endfunction

   // Huffman code, then the low mag_size bits of the value (ones' complement if negative)
   task automatic push_code(input huff_table_type t, input logic [7:0] sym, input int value,
                            input int mag_size, input logic blk_end, input logic last);
      code_word_type          w;
      logic [CODE_BITS_W-1:0] mag;
      mag           = (value < 0) ? CODE_BITS_W'(value - 1) : CODE_BITS_W'(value);
      mag           = mag & ((CODE_BITS_W'(1) << mag_size) - CODE_BITS_W'(1));
      w.bits        = (CODE_BITS_W'(huff_code[t][sym]) << mag_size) | mag;
      w.length      = CODE_LEN_W'(int'(huff_len[t][sym]) + mag_size);
      w.block_end   = blk_end;
      w.last_of_run = last;
      pending_codes.push_back(w);
   endtask

   task automatic encode_coefficient(input logic signed [COEFF_W-1:0] coef,
                                     input logic [COMP_W-1:0] comp);
      logic [COMP_W-1:0] c;
      huff_table_type    dc_tab;
      huff_table_type    ac_tab;
      int                value;
      int                diff;
      int                mag_size;
      logic              at_end;
      c      = (comp == COMP_RSVD) ? COMP_CR : comp;
      dc_tab = (c == COMP_Y) ? DC_LUMA : DC_CHR;
      ac_tab = (c == COMP_Y) ? AC_LUMA : AC_CHR;
      value  = int'(coef);
      at_end = (coeff_pos == 6'(BLOCK_COEFFS - 1));
      if (coeff_pos == '0) begin
         diff = value - int'(dc_prev[c]);
         if (diff > 2047) begin
            diff = 2047;
         end else if (diff < -2047) begin
            diff = -2047;
         end
         dc_prev[c] = 12'(value);
         mag_size   = magnitude_size(diff);
         push_code(dc_tab, 8'(mag_size), diff, mag_size, 1'b0, 1'b1);
         zero_run = '0;
      end else if (value == 0) begin
         zero_run = zero_run + 6'd1;
         if (at_end) begin
            push_code(ac_tab, EOB_SYM, 0, 0, 1'b1, 1'b1);
            eob_words++;
         end
      end else begin
         if (value < -1023) begin
            value = -1023;
         end
         while (zero_run > 6'd15) begin
            push_code(ac_tab, ZRL_SYM, 0, 0, 1'b0, 1'b0);
            zero_run = zero_run - 6'(ZRL_RUN);
            zrl_words++;
         end
         mag_size = magnitude_size(value);
         push_code(ac_tab, {zero_run[3:0], 4'(mag_size)}, value, mag_size, at_end, 1'b1);
         zero_run = '0;
      end
      coeff_pos = coeff_pos + 6'd1;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      $display("%0t ns: code word mismatch on %s: got 0x%0h, want 0x%0h",
               $time, what, got, wanted);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_codes.delete();
         dc_prev       = '{default: '0};
         zero_run      = '0;
         coeff_pos     = '0;
         mismatches    = 0;
         words_checked = 0;
         zrl_words     = 0;
         eob_words     = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            encode_coefficient(req_mon.coefficient, req_mon.component);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_codes.size() == 0) begin
               report_mismatch("code word with none pending, bits",
                               32'(rsp_mon.code_bits), 32'd0);
            end else begin
               want = pending_codes.pop_front();
               words_checked++;
               if (rsp_mon.code_bits !== want.bits) begin
                  report_mismatch("code_bits", 32'(rsp_mon.code_bits), 32'(want.bits));
               end
               if (rsp_mon.code_length !== want.length) begin
                  report_mismatch("code_length", 32'(rsp_mon.code_length),
                                  32'(want.length));
               end
               if (rsp_mon.block_end !== want.block_end) begin
                  report_mismatch("block_end", 32'(rsp_mon.block_end),
                                  32'(want.block_end));
               end
               if (rsp_mon.last_of_run !== want.last_of_run) begin
                  report_mismatch("last_of_run", 32'(rsp_mon.last_of_run),
                                  32'(want.last_of_run));
               end
            end
         end
      end
      words_pending = pending_codes.size();
   end

endmodule

[tb/tb_jpeg_block_entropy_encoder.sv]
`timescale 1ns / 100ps

module tb_jpeg_block_entropy_encoder;
   import jbe_pkg::*;

   localparam int RANDOM_REQUESTS = 435;
   localparam int MAX_GAP         = 10;
   localparam int DRAIN_CYCLES    = 10;

   // Directed opening: DC at full scale, AC extremes including the value that
   // saturates, a 16-zero run that forces one ZRL, and component switches
   // (Cb, Cr and the spare code 3) in the middle of the block.
   localparam logic signed [COEFF_W-1:0] DIRECTED_COEF [25] = '{
      0: 1023, 1: 1023, 2: -1024, 3: 1, 4: -1, 21: 512, 23: -3, 24: 7, default: 0};
   localparam logic [COMP_W-1:0] DIRECTED_COMP [25] = '{
      22: COMP_CB, 23: COMP_CR, 24: COMP_RSVD, default: COMP_Y};

   logic clock = 1'b0;
   logic reset = 1'b1;

   // set per block: when high, neither side idles
   bit   quiet = 1'b0;

   int   requests_sent = 0;
   int   block_pos     = 0;
   int   mismatches;
   int   words_pending;
   int   words_checked;
   int   zrl_words;
   int   eob_words;

   jbe_req_if req_ch ();
   jbe_rsp_if rsp_ch ();

   jpeg_block_entropy_encoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predicts every code word and compares it with what comes out
   jbe_huffman_checker code_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .mismatches    (mismatches),
      .words_pending (words_pending),
      .words_checked (words_checked),
      .zrl_words     (zrl_words),
      .eob_words     (eob_words)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: ends the run as a failure if it hangs.
   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

   // Random nonzero AC value: pick a magnitude class first so small and
   // large sizes get equal weight; now and then the clipped value -1024.
   function automatic logic signed [COEFF_W-1:0] rand_ac_value();
      int mag_size;
      int mag;
      if ($urandom_range(0, 15) == 0) begin
         return COEFF_W'(-1024);
      end
      mag_size = $urandom_range(1, 10);
      mag      = $urandom_range((1 << mag_size) - 1, 1 << (mag_size - 1));
      return ($urandom_range(0, 1) == 1) ? COEFF_W'(-mag) : COEFF_W'(mag);
   endfunction

   // One request: idle for a random gap, then hold valid until accepted.
   // valid is left high after acceptance; the next call lowers or reuses it
   // at its own falling edge so it is never written twice in one step.
   task automatic send_request(input logic signed [COEFF_W-1:0] coef,
                               input logic [COMP_W-1:0] comp);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.coefficient <= coef;
      req_ch.component   <= comp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
      block_pos = (block_pos + 1) % BLOCK_COEFFS;
   endtask

   // Stop sending and wait until every predicted code word has come out.
   task automatic drain_codes();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
   endtask

   // Result side: a random stall before each code word, then ready until
   // one is taken.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin
      int                        zero_pct;
      int                        tail;
      int                        blk_comp;
      int                        block_num;
      bit                        end_nonzero;
      logic signed [COEFF_W-1:0] coef;
      logic [COMP_W-1:0]         comp;

      req_ch.valid       = 1'b0;
      req_ch.coefficient = '0;
      req_ch.component   = COMP_Y;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part: first 25 positions of a luma block ----
      for (int i = 0; i < 25; i++) begin
         send_request(DIRECTED_COEF[i], DIRECTED_COMP[i]);
      end

      // sender holds off mid-block until all code words are out
      drain_codes();

      // ---- random part ----
      // The directed block is finished with a sparse luma tail ending in EOB.
      // Each new block then draws a component, a zero density, an optional
      // early cutoff (trailing zeros before position 63), and whether the
      // last position is nonzero (alternating, so both endings occur).
      zero_pct    = 85;
      tail        = BLOCK_COEFFS;
      blk_comp    = COMP_Y;
      end_nonzero = 1'b0;
      block_num   = 0;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (block_pos == 0) begin
            block_num++;
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
               drain_codes();
            end
            blk_comp = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
               0: begin
                  zero_pct = 10;
               end
               1: begin
                  zero_pct = 50;
               end
               2: begin
                  zero_pct = 85;
               end
               default: begin
                  zero_pct = 97;
               end
            endcase
            tail        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 63) : BLOCK_COEFFS;
            end_nonzero = block_num[0];
            // luma DC went to 1023 above; -1024 now gives the widest difference
            if (block_num == 1) begin
               blk_comp = COMP_Y;
            end
         end

         // occasional component switch inside a block
         if (block_pos != 0 && $urandom_range(0, 7) == 0) begin
            comp = COMP_W'($urandom_range(0, 3));
         end else begin
            comp = COMP_W'(blk_comp);
         end

         if (block_pos == 0) begin
            case ($urandom_range(0, 5))
               0: begin
                  coef = COEFF_W'(-1024);
               end
               1: begin
                  coef = COEFF_W'(1023);
               end
               2: begin
                  coef = '0;
               end
               default: begin
                  coef = COEFF_W'($urandom());
               end
            endcase
            if (block_num == 1) begin
               coef = COEFF_W'(-1024);
            end
         end else if (block_pos == BLOCK_COEFFS - 1) begin
            coef = end_nonzero ? rand_ac_value() : '0;
         end else if (block_pos >= tail || $urandom_range(1, 100) <= zero_pct) begin
            coef = '0;
         end else begin
            coef = rand_ac_value();
         end
         send_request(coef, comp);
      end

      // ---- wind down ----
      drain_codes();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run: %0d requests over %0d blocks, all four component codes, gaps 0..%0d",
               requests_sent, (requests_sent + BLOCK_COEFFS - 1) / BLOCK_COEFFS, MAX_GAP);
      $display("run: %0d code words checked, %0d of them ZRL and %0d EOB",
               words_checked, zrl_words, eob_words);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/jbe_pkg.sv
rtl/jbe_req_if.sv
rtl/jbe_rsp_if.sv
rtl/jpeg_block_entropy_encoder.sv
rtl/jbe_checker.sv
tb/jbe_huffman_checker.sv
tb/tb_jpeg_block_entropy_encoder.sv
